// ----- design/rtss_pkg.sv -----
// rtss_pkg: shared types, codes and the record ordering function for the
// record table block. No dependencies.
package rtss_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND   = 3'd0,
		CMD_SET_INFO = 3'd1,
		CMD_SORT_KEY = 3'd2,
		CMD_SORT_POS = 3'd3,
		CMD_SORT_EVL = 3'd4,
		CMD_FIND     = 3'd5,
		CMD_READ     = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [30:0] key;
		logic [3:0]  position;
		logic [7:0]  evaluation;
	} rec_t;

	typedef struct packed {
		cmd_t        command;
		logic [30:0] key;
		logic [5:0]  slot;
		logic [3:0]  new_position;
		logic [7:0]  new_evaluation;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  found_slot;
		logic [30:0] rec_key;
		logic [3:0]  rec_position;
		logic [7:0]  rec_evaluation;
		logic [6:0]  entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_SORT,
		OP_WR_KEY,
		OP_WR_INFO
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		cmd_t        mode;
		logic [30:0] key;
		logic [3:0]  position;
		logic [7:0]  evaluation;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN,
		S_ACT,
		S_SEARCH,
		S_SORT,
		S_DONE
	} state_t;

	// true when record a belongs after record b
	function automatic logic comes_after(input cmd_t mode, input rec_t a, input rec_t b);
		logic r;
		unique case (mode)
			CMD_SORT_KEY: r = a.key > b.key;
			CMD_SORT_POS: r = a.position > b.position;
			default:      r = a.evaluation < b.evaluation;
		endcase
		return r;
	endfunction

endpackage

// ----- design/record_table_sort_and_search.sv -----
// record_table_sort_and_search: top level, ring of rtss_cell slots and the
// command sequencer. Depends on rtss_pkg and rtss_cell.
//
// The table is a ring of DEPTH cells that rotates one place a cycle to bring
// an addressed record to the head cell. A command takes one request at a time:
// append, set info and read rotate the addressed slot to the head cell and
// then act there; find takes up to log2(DEPTH)+1 probes, each such a rotation;
// a sort aligns the ring and then runs one odd-even compare and exchange
// pass a cycle, record count passes. A new request is taken while the last
// result still waits.
module record_table_sort_and_search #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rtss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rtss_pkg::rsp_t rsp
);
	import rtss_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	state_t             state_q, state_n;
	req_t               req_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      h_q;
	logic [IW-1:0]      target_q;
	logic signed [SW-1:0] lo_q, hi_q;
	logic [CW-1:0]      pass_q;
	logic               phase_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	cell_ctrl_t         ctrl;
	rec_t               recs [DEPTH];
	logic [DEPTH-1:0]   swaps;
	logic [DEPTH-1:0]   pair_en;

	logic               aligned;
	logic signed [SW-1:0] mid;
	logic               take;
	logic               emit;
	rsp_t               res_init;
	rsp_t               rsp_n;

	assign aligned   = h_q == target_q;
	assign mid       = lo_q + ((hi_q - lo_q) >>> 1);
	assign req_stall = state_q != S_IDLE;
	assign take      = req_valid && !req_stall;
	assign emit      = state_q == S_DONE && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	genvar c;
	generate
		for (c = 0; c < DEPTH; c++) begin : g_cell
			cell_ctrl_t cc;
			always_comb begin
				cc = ctrl;
				if (c != 0 && (ctrl.op == OP_WR_KEY || ctrl.op == OP_WR_INFO)) begin
					cc.op = OP_HOLD;
				end
			end
			assign pair_en[c] = (((c % 2) == 1) == phase_q) && (32'(c + 1) < 32'(count_q));
			rtss_cell u_cell (
				.clk       (clk),
				.ctrl      (cc),
				.pair_en   (pair_en[c]),
				.swap_left ((c == 0) ? 1'b0 : swaps[(c + DEPTH - 1) % DEPTH]),
				.rec_left  (recs[(c + DEPTH - 1) % DEPTH]),
				.rec_right (recs[(c + 1) % DEPTH]),
				.swap_out  (swaps[c]),
				.rec       (recs[c])
			);
		end
	endgenerate

	always_comb begin
		res_init = '0;
		priority case (req.command)
			CMD_APPEND: begin
				if (32'(count_q) >= 32'(DEPTH)) begin
					res_init.status = ST_FULL;
				end
			end
			CMD_SET_INFO, CMD_READ: begin
				if (32'(req.slot) >= 32'(count_q)) begin
					res_init.status = ST_BAD_INDEX;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp_n             = res_q;
		rsp_n.entry_count = 7'(count_q);
	end

	always_comb begin
		state_n         = state_q;
		ctrl.op         = OP_HOLD;
		ctrl.mode       = req_q.command;
		ctrl.key        = req_q.key;
		ctrl.position   = req_q.new_position;
		ctrl.evaluation = req_q.new_evaluation;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					priority case (req.command)
						CMD_APPEND: begin
							state_n = (32'(count_q) >= 32'(DEPTH)) ? S_DONE : S_ALIGN;
						end
						CMD_SET_INFO, CMD_READ: begin
							state_n = (32'(req.slot) >= 32'(count_q)) ? S_DONE : S_ALIGN;
						end
						CMD_SORT_KEY, CMD_SORT_POS, CMD_SORT_EVL: begin
							state_n = (count_q < CW'(2)) ? S_DONE : S_ALIGN;
						end
						CMD_FIND: state_n = S_SEARCH;
						default:  state_n = S_DONE;
					endcase
				end
			end
			S_ALIGN: begin
				if (aligned) begin
					state_n = S_ACT;
				end else begin
					ctrl.op = OP_ROTATE;
				end
			end
			S_ACT: begin
				priority case (req_q.command)
					CMD_APPEND: begin
						ctrl.op = OP_WR_KEY;
						state_n = S_DONE;
					end
					CMD_SET_INFO: begin
						ctrl.op = OP_WR_INFO;
						state_n = S_DONE;
					end
					CMD_FIND: begin
						state_n = (recs[0].key == req_q.key) ? S_DONE : S_SEARCH;
					end
					CMD_SORT_KEY, CMD_SORT_POS, CMD_SORT_EVL: state_n = S_SORT;
					default: state_n = S_DONE;
				endcase
			end
			S_SEARCH: begin
				state_n = (lo_q > hi_q) ? S_DONE : S_ALIGN;
			end
			S_SORT: begin
				ctrl.op = OP_SORT;
				if (pass_q == count_q - CW'(1)) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (emit) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			h_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.op == OP_ROTATE) begin
				h_q <= (32'(h_q) == DEPTH - 1) ? '0 : h_q + IW'(1);
			end
			if (state_q == S_ACT && req_q.command == CMD_APPEND) begin
				count_q <= count_q + CW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_n;
		end
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					req_q   <= req;
					res_q   <= res_init;
					lo_q    <= '0;
					hi_q    <= SW'(count_q) - SW'(1);
					pass_q  <= '0;
					phase_q <= 1'b0;
					priority case (req.command)
						CMD_APPEND:             target_q <= IW'(count_q);
						CMD_SET_INFO, CMD_READ: target_q <= IW'(req.slot);
						default:                target_q <= '0;
					endcase
				end
			end
			S_ACT: begin
				if (req_q.command == CMD_READ) begin
					res_q.rec_key        <= recs[0].key;
					res_q.rec_position   <= recs[0].position;
					res_q.rec_evaluation <= recs[0].evaluation;
				end else if (req_q.command == CMD_FIND) begin
					if (recs[0].key == req_q.key) begin
						res_q.found_slot <= 6'(target_q);
					end else if (recs[0].key > req_q.key) begin
						hi_q <= SW'(target_q) - SW'(1);
					end else begin
						lo_q <= SW'(target_q) + SW'(1);
					end
				end
			end
			S_SEARCH: begin
				if (lo_q > hi_q) begin
					res_q.status <= ST_NOT_FOUND;
				end else begin
					target_q <= IW'(mid);
				end
			end
			S_SORT: begin
				pass_q  <= pass_q + CW'(1);
				phase_q <= !phase_q;
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("record count above table depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(h_q) < DEPTH)
		else $error("ring head index out of range");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> state_q == S_IDLE && rsp_valid_q)
		else $error("result issued without returning to idle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_ACT |=> count_q == $past(count_q))
		else $error("record count changed outside an append");

endmodule

// ----- design/rtss_cell.sv -----
// rtss_cell: one table slot; rotates with its neighbour, does odd-even
// compare and exchange, takes writes. Depends on rtss_pkg.
module rtss_cell (
	input  logic               clk,
	input  rtss_pkg::cell_ctrl_t ctrl,
	input  logic               pair_en,
	input  logic               swap_left,
	input  rtss_pkg::rec_t     rec_left,
	input  rtss_pkg::rec_t     rec_right,
	output logic               swap_out,
	output rtss_pkg::rec_t     rec
);
	import rtss_pkg::*;

	rec_t rec_q;

	assign rec = rec_q;
	assign swap_out = pair_en && comes_after(ctrl.mode, rec_q, rec_right);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_ROTATE: rec_q <= rec_right;
			OP_SORT: begin
				if (swap_out) begin
					rec_q <= rec_right;
				end else if (swap_left) begin
					rec_q <= rec_left;
				end
			end
			OP_WR_KEY: begin
				rec_q.key        <= ctrl.key;
				rec_q.position   <= '0;
				rec_q.evaluation <= '0;
			end
			OP_WR_INFO: begin
				rec_q.position   <= ctrl.position;
				rec_q.evaluation <= ctrl.evaluation;
			end
			default: rec_q <= rec_q;
		endcase
	end

endmodule

// ----- tb/record_table_sort_and_search_tb.sv -----
`timescale 1ns / 100ps
// record_table_sort_and_search_tb: drives table commands into the record table,
// predicts each result with its own table copy and checks every response.
// Depends on rtss_pkg and record_table_sort_and_search.
module record_table_sort_and_search_tb;
	import rtss_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	record_table_sort_and_search #(.DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// shadow table
	rec_t table_copy [DEPTH];
	int unsigned rec_total;
	int unsigned rec_total_hint;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int unsigned mismatch_count;
	int unsigned send_idle_pct, recv_idle_pct;
	bit hold_off, send_pause;
	int unsigned hold_cycles;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit rec_after(cmd_t mode, rec_t a, rec_t b);
		case (mode)
			CMD_SORT_KEY: return a.key > b.key;
			CMD_SORT_POS: return a.position > b.position;
			default: return a.evaluation < b.evaluation;
		endcase
	endfunction

	function automatic rsp_t table_predict(req_t r);
		rsp_t o;
		rec_t t;
		int lo, hi, mid, j;
		o = '0;
		o.status = ST_OK;
		case (r.command)
			CMD_APPEND: begin
				if (rec_total >= DEPTH) o.status = ST_FULL;
				else begin
					table_copy[rec_total] = '{key: r.key, position: 4'd0, evaluation: 8'd0};
					rec_total++;
				end
			end
			CMD_SET_INFO: begin
				if (r.slot >= rec_total) o.status = ST_BAD_INDEX;
				else begin
					table_copy[r.slot].position = r.new_position;
					table_copy[r.slot].evaluation = r.new_evaluation;
				end
			end
			CMD_SORT_KEY, CMD_SORT_POS, CMD_SORT_EVL: begin
				for (int i = 1; i < rec_total; i++) begin
					j = i;
					while (j > 0 && rec_after(r.command, table_copy[j-1], table_copy[j])) begin
						t = table_copy[j-1];
						table_copy[j-1] = table_copy[j];
						table_copy[j] = t;
						j--;
					end
				end
			end
			CMD_FIND: begin
				lo = 0;
				hi = int'(rec_total) - 1;
				o.status = ST_NOT_FOUND;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (table_copy[mid].key == r.key) begin
						o.status = ST_OK;
						o.found_slot = mid[5:0];
						break;
					end
					if (table_copy[mid].key > r.key) hi = mid - 1;
					else lo = mid + 1;
				end
			end
			CMD_READ: begin
				if (r.slot >= rec_total) o.status = ST_BAD_INDEX;
				else begin
					o.rec_key = table_copy[r.slot].key;
					o.rec_position = table_copy[r.slot].position;
					o.rec_evaluation = table_copy[r.slot].evaluation;
				end
			end
			default: ;
		endcase
		o.entry_count = rec_total[6:0];
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				expected_rsps.push_back(table_predict(req));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > 0 && !send_pause
					&& $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected response %p", rsp);
				end else begin
					if (rsp.status !== expected_rsps[0].status
							|| rsp.found_slot !== expected_rsps[0].found_slot
							|| rsp.rec_key !== expected_rsps[0].rec_key
							|| rsp.rec_position !== expected_rsps[0].rec_position
							|| rsp.rec_evaluation !== expected_rsps[0].rec_evaluation
							|| rsp.entry_count !== expected_rsps[0].entry_count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected %p actual %p",
								expected_rsps[0], rsp);
					end
					void'(expected_rsps.pop_front());
				end
			end
			if (hold_off && hold_cycles < 3000) begin
				hold_cycles <= hold_cycles + 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic req_t make_req(cmd_t c, logic [30:0] k, logic [5:0] s,
			logic [3:0] p, logic [7:0] e);
		req_t r;
		r.command = c;
		r.key = k;
		r.slot = s;
		r.new_position = p;
		r.new_evaluation = e;
		return r;
	endfunction

	function automatic req_t rand_req(int unsigned keyspan);
		req_t r;
		int unsigned w;
		r = make_req(CMD_NONE, 31'($urandom_range(keyspan)), 6'($urandom),
			4'($urandom), 8'($urandom));
		if ($urandom_range(9) == 0) r.key = 31'($urandom);
		w = $urandom_range(99);
		if (w < 30) r.command = CMD_APPEND;
		else if (w < 50) r.command = CMD_SET_INFO;
		else if (w < 58) r.command = cmd_t'($urandom_range(4, 2));
		else if (w < 78) r.command = CMD_FIND;
		else if (w < 97) r.command = CMD_READ;
		if (r.command inside {CMD_SET_INFO, CMD_READ} && $urandom_range(9) != 0
				&& rec_total_hint > 0)
			r.slot = 6'($urandom_range(rec_total_hint - 1));
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned n;
		rec_total = 0;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 12;
		recv_idle_pct = 79;
		hold_off = 0;
		send_pause = 0;
		rec_total_hint = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		pending_reqs.push_back(make_req(CMD_FIND, 31'd5, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SET_INFO, 31'd0, 6'd63, 4'hF, 8'hFF));
		pending_reqs.push_back(make_req(CMD_APPEND, 31'h7FFFFFFF, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_APPEND, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_APPEND, 31'd7, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_APPEND, 31'd7, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SET_INFO, 31'd0, 6'd0, 4'hF, 8'd0));
		pending_reqs.push_back(make_req(CMD_SET_INFO, 31'd0, 6'd2, 4'd3, 8'hFF));
		pending_reqs.push_back(make_req(CMD_SET_INFO, 31'd0, 6'd3, 4'd3, 8'hFF));
		pending_reqs.push_back(make_req(CMD_SET_INFO, 31'h7FFFFFFF, 6'd4, 4'd1, 8'd1));
		pending_reqs.push_back(make_req(CMD_FIND, 31'd7, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SORT_EVL, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SORT_POS, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd1, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SORT_KEY, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_FIND, 31'h7FFFFFFF, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_FIND, 31'd3, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd3, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd4, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_NONE, 31'h7FFFFFFF, 6'h3F, 4'hF, 8'hFF));
		for (int i = 0; i < 62; i++)
			pending_reqs.push_back(make_req(CMD_APPEND, 31'($urandom_range(63)), 6'd0,
				4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_READ, 31'd0, 6'd63, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_SORT_KEY, 31'd0, 6'd0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(CMD_FIND, 31'd20, 6'd0, 4'd0, 8'd0));
		wait_drained();

		// long receiver hold-off while requests keep coming, then a sender pause
		hold_off = 1;
		rec_total_hint = 64;
		for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(63));
		wait (hold_cycles >= 3000);
		hold_off = 0;
		send_pause = 1;
		while (req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		send_pause = 0;
		wait_drained();

		// random phases: varied sender and receiver idle rates on the filled table
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 79;
				recv_idle_pct = 12;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			n = 0;
			while (n < 540) begin
				req_t r;
				if (pending_reqs.size() > 8) begin
					@(posedge clk);
					continue;
				end
				rec_total_hint = rec_total;
				r = rand_req(($urandom_range(3) == 0) ? 1000 : 40);
				// keep the sorted-and-found path well exercised
				if ($urandom_range(19) == 0 && r.command == CMD_APPEND) begin
					pending_reqs.push_back(make_req(CMD_SORT_KEY, r.key, 6'd0, 4'd0, 8'd0));
					n++;
				end
				pending_reqs.push_back(r);
				n++;
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
